>>> hw/rtl/assert_macros.svh
// assertion macros used by the list controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ilir_pkg.sv
// shared types and constants of the indexed list block
package ilir_pkg;

   // defaults for the top level parameters
   localparam int DEPTH_DEF = 16;
   localparam int WIDTH_DEF = 32;

   // fixed port field widths
   localparam int CMD_W    = 3;
   localparam int POS_W    = 8;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_SET    = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_GET    = 3'd4,
      CMD_REMOVE = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_OOB   = 2'd3
   } status_type;

   // what every cell does at each clock edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   // broadcast from the controller to the row of cells
   typedef struct packed {
      cell_op_type        op;
      logic [POS_W-1:0]   target;
   } cell_cmd_type;

endpackage

>>> hw/rtl/ilir_cell.sv
// one storage cell of the list row, shifts with its neighbors
module ilir_cell #(
   parameter int WIDTH = ilir_pkg::WIDTH_DEF,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  ilir_pkg::cell_cmd_type cmd,
   input  logic [WIDTH-1:0]      word_load,
   input  logic [WIDTH-1:0]      left_word,
   input  logic [WIDTH-1:0]      right_word,
   output logic [WIDTH-1:0]      value
);
   import ilir_pkg::*;

   localparam logic [POS_W-1:0] MY_INDEX = POS_W'(INDEX);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;

   // pick the next value from the broadcast command
   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         CELL_LOAD: begin
            if (MY_INDEX == cmd.target) value_in = word_load;
         end
         CELL_INSERT: begin
            if (MY_INDEX > cmd.target) value_in = left_word;
            else if (MY_INDEX == cmd.target) value_in = word_load;
         end
         CELL_REMOVE: begin
            if (MY_INDEX >= cmd.target) value_in = right_word;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> hw/rtl/ilir_ctrl.sv
// command decode, live count and result registers of the list
module ilir_ctrl #(
   parameter int DEPTH = ilir_pkg::DEPTH_DEF,
   parameter int WIDTH = ilir_pkg::WIDTH_DEF,
   localparam int CW   = $clog2(DEPTH + 1),
   localparam int IDXW = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ilir_pkg::CMD_W-1:0]    req_cmd,
   input  logic [ilir_pkg::POS_W-1:0]    req_position,
   input  logic [ilir_pkg::WORD_W-1:0]   req_word_in,
   output ilir_pkg::cell_cmd_type        cell_cmd,
   output logic [WIDTH-1:0]              cell_word,
   output logic [IDXW-1:0]               rd_index,
   input  logic [WIDTH-1:0]              rd_word,
   output logic                          rsp_strobe,
   output logic [ilir_pkg::STATUS_W-1:0] rsp_status,
   output logic [ilir_pkg::WORD_W-1:0]   rsp_word_out,
   output logic [CW-1:0]                 rsp_count
);
   import ilir_pkg::*;

   `include "assert_macros.svh"

   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic              busy_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              strobe_ff;
   status_type        status_ff;
   status_type        status_in;
   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_out_in;
   logic              fire;
   logic              is_full;
   logic              is_empty;
   logic              rd_hit;
   logic [CMPW-1:0]   pos_ext;
   logic [CMPW-1:0]   cnt_ext;

   assign busy     = busy_ff | reset;
   assign fire     = start & ~busy;
   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);
   assign pos_ext  = CMPW'(req_position);
   assign cnt_ext  = CMPW'(count_ff);
   assign cell_word = WIDTH'(req_word_in);

   // decode the command against the live count
   always_comb begin
      count_in    = count_ff;
      status_in   = ST_OK;
      rd_hit      = 1'b0;
      rd_index    = IDXW'(req_position);
      cell_cmd.op     = CELL_HOLD;
      cell_cmd.target = req_position;
      case (cmd_type'(req_cmd))
         CMD_PUSH: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               cell_cmd.op     = CELL_LOAD;
               cell_cmd.target = POS_W'(count_ff);
               count_in        = count_ff + 1'b1;
            end
         end
         CMD_POP: begin
            rd_index = IDXW'(count_ff - 1'b1);
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_hit   = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_SET: begin
            if (pos_ext >= cnt_ext) status_in = ST_OOB;
            else cell_cmd.op = CELL_LOAD;
         end
         CMD_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_in = ST_OOB;
            end else if (is_full) begin
               status_in = ST_FULL;
            end else begin
               cell_cmd.op = CELL_INSERT;
               count_in    = count_ff + 1'b1;
            end
         end
         CMD_GET: begin
            if (pos_ext >= cnt_ext) status_in = ST_OOB;
            else rd_hit = 1'b1;
         end
         CMD_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ST_OOB;
            end else begin
               cell_cmd.op = CELL_REMOVE;
               count_in    = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      if (!fire) begin
         cell_cmd.op = CELL_HOLD;
         count_in    = count_ff;
      end
      word_out_in = rd_hit ? WORD_W'(rd_word) : '0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         count_ff  <= count_in;
         strobe_ff <= fire;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_in;
         word_ff   <= word_out_in;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_word_out = word_ff;
   assign rsp_count    = count_ff;

   `ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_COUNT, "live count above depth")
   `ASSERT_NEXT(a_strobe_follows, fire, strobe_ff, "accepted word gave no result")
   `ASSERT_NEXT(a_count_stable, !fire, $stable(count_ff), "count moved without a command")
   `ASSERT_NEXT(a_pop_count, fire && req_cmd == CMD_POP && !is_empty,
      count_ff == CW'($past(count_ff) - 1'b1), "pop did not lower the count")

endmodule

>>> hw/rtl/indexed_list_insert_remove_top.sv
// top level of the indexed list with insert and remove
//
// Ordered list of up to DEPTH words held in a row of cells, with a live count.
// Commands: push, pop, set, insert, get, remove on req_cmd, with req_position
// and req_word_in. A command is taken at a clock edge where start is high and
// busy is low. busy is high only during reset and the cycle after it.
// Every command gives exactly one result on the cycle after it was taken:
// rsp_strobe is high for that one cycle with rsp_status, rsp_word_out and
// rsp_count (count after the command). The receiver cannot stall; results
// are simply presented for one cycle.
// Throughput is one command per cycle while busy is low; every cell updates
// from itself or a neighbor at the same clock edge, so insert and remove
// shift the whole row at once; a read picks one cell through a DEPTH-way mux.
// Reset clears the live count and the result strobe; the cell contents are
// left as they are, and are only read after being written again.
module indexed_list_insert_remove_top #(
   parameter int DEPTH = ilir_pkg::DEPTH_DEF,
   parameter int WIDTH = ilir_pkg::WIDTH_DEF,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ilir_pkg::CMD_W-1:0]    req_cmd,
   input  logic [ilir_pkg::POS_W-1:0]    req_position,
   input  logic [ilir_pkg::WORD_W-1:0]   req_word_in,
   output logic                          rsp_strobe,
   output logic [ilir_pkg::STATUS_W-1:0] rsp_status,
   output logic [ilir_pkg::WORD_W-1:0]   rsp_word_out,
   output logic [CW-1:0]                 rsp_count
);
   import ilir_pkg::*;

   localparam int IDXW = $clog2(DEPTH);

   cell_cmd_type     cell_cmd;
   logic [WIDTH-1:0] cell_word;
   logic [IDXW-1:0]  rd_index;
   logic [WIDTH-1:0] rd_word;
   logic [WIDTH-1:0] cell_value [DEPTH];

   // decode and result registers
   ilir_ctrl #(
      .DEPTH(DEPTH),
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .cell_cmd     (cell_cmd),
      .cell_word    (cell_word),
      .rd_index     (rd_index),
      .rd_word      (rd_word),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_word_out (rsp_word_out),
      .rsp_count    (rsp_count)
   );

   // row of cells wired to their neighbors, cell_word at the left end
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left_word;
      logic [WIDTH-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = cell_word;
      end else begin : g_inner_l
         assign left_word = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_value[i];
      end else begin : g_inner_r
         assign right_word = cell_value[i+1];
      end

      ilir_cell #(
         .WIDTH(WIDTH),
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .word_load  (cell_word),
         .left_word  (left_word),
         .right_word (right_word),
         .value      (cell_value[i])
      );
   end

   // read select for get and pop
   assign rd_word = cell_value[rd_index];

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the indexed list with insert and remove
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ilir_pkg::*;

   localparam int DEPTH      = DEPTH_DEF;
   localparam int WIDTH      = WIDTH_DEF;
   localparam int CW         = $clog2(DEPTH + 1);
   localparam int CYCLE_CAP  = 200000;
   localparam int RANDOM_LEN = 1200;
   localparam int REPORT_MAX = 10;

   // command codes the block does not decode, expected to act as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   // the part of a word that the list keeps
   localparam logic [WORD_W-1:0] KEEP_MASK =
      (WIDTH >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << WIDTH) - 64'd1);

   typedef struct packed {
      status_type         status;
      logic [WORD_W-1:0]  word;
      logic [CW-1:0]      count;
   } list_reply_type;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd      = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [WORD_W-1:0]   req_word_in  = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [WORD_W-1:0]   rsp_word_out;
   logic [CW-1:0]       rsp_count;

   // shadow copy of the list contents and its length
   logic [WORD_W-1:0]   shadow_list [DEPTH];
   int                  shadow_len = 0;

   list_reply_type      pending_replies [$];
   bit                  idle_on     = 1'b0;
   int                  mismatches  = 0;
   int                  cycle_count = 0;
   int                  words_sent  = 0;
   int                  replies_checked = 0;
   int                  cmd_seen    [8];
   int                  status_seen [4];

   indexed_list_insert_remove_top #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_word_out (rsp_word_out),
      .rsp_count    (rsp_count)
   );

   always #1 clock = ~clock;

   // apply one command to the shadow list and return what the block should answer
   function automatic list_reply_type apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                     logic [POS_W-1:0] pos,
                                                     logic [WORD_W-1:0] word);
      list_reply_type reply;
      int             p;
      p            = int'(pos);
      reply.status = ST_OK;
      reply.word   = '0;
      word         = word & KEEP_MASK;
      case (cmd)
         CMD_PUSH: begin
            if (shadow_len >= DEPTH) reply.status = ST_FULL;
            else begin
               shadow_list[shadow_len] = word;
               shadow_len++;
            end
         end
         CMD_POP: begin
            if (shadow_len == 0) reply.status = ST_EMPTY;
            else begin
               shadow_len--;
               reply.word = shadow_list[shadow_len];
            end
         end
         CMD_SET: begin
            if (p >= shadow_len) reply.status = ST_OOB;
            else shadow_list[p] = word;
         end
         CMD_INSERT: begin
            // a bad index wins over a full list
            if (p > shadow_len) reply.status = ST_OOB;
            else if (shadow_len >= DEPTH) reply.status = ST_FULL;
            else begin
               for (int i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[p] = word;
               shadow_len++;
            end
         end
         CMD_GET: begin
            if (p >= shadow_len) reply.status = ST_OOB;
            else reply.word = shadow_list[p];
         end
         CMD_REMOVE: begin
            // the deleted word is not returned
            if (p >= shadow_len) reply.status = ST_OOB;
            else begin
               for (int i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
               shadow_len--;
            end
         end
         default: ;
      endcase
      reply.count = CW'(shadow_len);
      cmd_seen[cmd]++;
      status_seen[reply.status]++;
      return reply;
   endfunction

   // drive one command word and wait until the block takes it
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                            logic [WORD_W-1:0] word);
      int gap;
      if (idle_on && $urandom_range(0, 99) < 33) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            start        <= 1'b0;
            req_cmd      <= CMD_W'($urandom);
            req_position <= POS_W'($urandom);
            req_word_in  <= $urandom;
         end
      end
      @(negedge clock);
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_position <= pos;
      req_word_in  <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_replies.push_back(apply_list_cmd(cmd, pos, word));
      words_sent++;
   endtask

   task automatic note_mismatch(string field, logic [WORD_W-1:0] exp_val,
                                logic [WORD_W-1:0] act_val);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("tb_top: mismatch on %s at cycle %0d: expected 0x%0h, got 0x%0h",
                  field, cycle_count, exp_val, act_val);
   endtask

   // compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      list_reply_type exp_reply;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            note_mismatch("unexpected result", '0, {30'd0, rsp_status});
         end else begin
            exp_reply = pending_replies.pop_front();
            replies_checked++;
            if (rsp_status !== exp_reply.status)
               note_mismatch("status", WORD_W'(exp_reply.status), WORD_W'(rsp_status));
            if (rsp_word_out !== exp_reply.word)
               note_mismatch("word_out", exp_reply.word, rsp_word_out);
            if (rsp_count !== exp_reply.count)
               note_mismatch("count", WORD_W'(exp_reply.count), WORD_W'(rsp_count));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // commands on an empty list, bad indices and undecoded codes
   task automatic test_empty_list();
      send_word(CMD_POP, 8'd0, 32'hFFFF_FFFF);
      send_word(CMD_GET, 8'd0, '0);
      send_word(CMD_SET, 8'd255, 32'hDEAD_BEEF);
      send_word(CMD_REMOVE, 8'd0, '0);
      send_word(CMD_INSERT, 8'd1, 32'h1234_5678);
      send_word(CMD_SPARE_LO, 8'd0, 32'hFFFF_FFFF);
      send_word(CMD_SPARE_HI, 8'd255, 32'hFFFF_FFFF);
      // insert at the current length is an append
      send_word(CMD_INSERT, 8'd0, 32'hA5A5_A5A5);
      send_word(CMD_SPARE_LO, 8'd0, '0);
      send_word(CMD_REMOVE, 8'd0, '0);
   endtask

   // fill to capacity, hit the full and bound cases, then drain past empty
   task automatic test_fill_and_limits();
      for (int i = 0; i < DEPTH; i++)
         send_word(CMD_PUSH, 8'd0, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF :
                   ((i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA) ^ i);
      send_word(CMD_PUSH, 8'd0, 32'h1111_1111);
      send_word(CMD_INSERT, 8'd3, 32'h2222_2222);
      send_word(CMD_INSERT, POS_W'(DEPTH), 32'h3333_3333);
      send_word(CMD_INSERT, POS_W'(DEPTH + 1), 32'h4444_4444);
      send_word(CMD_INSERT, 8'd255, 32'h4444_4444);
      send_word(CMD_GET, POS_W'(DEPTH - 1), '0);
      send_word(CMD_GET, POS_W'(DEPTH), '0);
      send_word(CMD_SET, POS_W'(DEPTH - 1), 32'hFFFF_FFFF);
      send_word(CMD_REMOVE, 8'd0, '0);
      send_word(CMD_REMOVE, POS_W'(DEPTH - 2), '0);
      send_word(CMD_INSERT, 8'd0, 32'h8000_0001);
      send_word(CMD_INSERT, POS_W'(DEPTH - 1), 32'h7FFF_FFFE);
      send_word(CMD_GET, 8'd0, '0);
      while (shadow_len > 0) send_word(CMD_POP, 8'd255, '0);
      send_word(CMD_POP, 8'd0, '0);
   endtask

   // weighted command choice, tilted toward growing or shrinking the list
   function automatic logic [CMD_W-1:0] pick_cmd(bit grow);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return r ? CMD_SPARE_HI : CMD_SPARE_LO;
      if (grow) begin
         if (r < 32) return CMD_PUSH;
         if (r < 57) return CMD_INSERT;
         if (r < 67) return CMD_SET;
         if (r < 80) return CMD_GET;
         if (r < 90) return CMD_POP;
         return CMD_REMOVE;
      end
      if (r < 12) return CMD_PUSH;
      if (r < 22) return CMD_INSERT;
      if (r < 32) return CMD_SET;
      if (r < 45) return CMD_GET;
      if (r < 72) return CMD_POP;
      return CMD_REMOVE;
   endfunction

   // index choice: mostly in range, with edges and wild values mixed in
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return POS_W'($urandom_range(0, shadow_len));
      if (r == 6) return (shadow_len > 0) ? POS_W'(shadow_len - 1) : '0;
      if (r == 7) return POS_W'(shadow_len);
      if (r == 8) return '0;
      return POS_W'($urandom_range(0, 255));
   endfunction

   // random traffic swinging between full and empty
   task automatic test_random_traffic();
      logic [CMD_W-1:0] cmd;
      int               useful;
      bit               grow;
      useful = 0;
      grow   = 1'b1;
      while (useful < RANDOM_LEN) begin
         // first stretch runs back to back
         idle_on = (useful >= 300);
         if (shadow_len == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
         if (shadow_len == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
         cmd = pick_cmd(grow);
         send_word(cmd, pick_position(), $urandom);
         if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) useful++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      idle_on = 1'b1;
      test_fill_and_limits();
      test_random_traffic();

      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("tb_top: %0d words sent, %0d results checked; push %0d pop %0d set %0d",
               words_sent, replies_checked, cmd_seen[CMD_PUSH], cmd_seen[CMD_POP],
               cmd_seen[CMD_SET]);
      $display("tb_top: insert %0d get %0d remove %0d; ok %0d full %0d empty %0d oob %0d",
               cmd_seen[CMD_INSERT], cmd_seen[CMD_GET], cmd_seen[CMD_REMOVE],
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_OOB]);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: %0d mismatches", mismatches);
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
